// ===== rtl/ptq_pkg.sv =====
package ptq_pkg;

  localparam int MAX_FIRE = 32;
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SCHED  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e_t;

  typedef enum logic [1:0] {
    REPLY_SCHED  = 2'd0,
    REPLY_CANCEL = 2'd1,
    REPLY_QUERY  = 2'd2,
    REPLY_FIRED  = 2'd3
  } reply_e_t;

  typedef enum logic [1:0] {
    SRCH_FREE = 2'd0,
    SRCH_ID   = 2'd1,
    SRCH_DUE  = 2'd2
  } srch_e_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_REARM = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_ACT   = 2'd2,
    ST_FLUSH = 2'd3
  } state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic        go;
    logic        found;
    logic        periodic;
    logic [63:0] ident;
    logic [63:0] due;
    logic [63:0] order;
  } tok_t;

  // write command broadcast to all cells
  typedef struct packed {
    cmd_e_t      kind;
    logic [63:0] ident;
    logic [63:0] due;
    logic [31:0] interval;
    logic [63:0] order;
  } cmd_t;

endpackage

// ===== rtl/ptq_cell.sv =====
module ptq_cell #(
  parameter int IW         = 4,
  parameter int CELL_INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  ptq_pkg::srch_e_t srch,
  input  logic [63:0]      cur_time,
  input  logic [63:0]      key_id,
  input  ptq_pkg::tok_t    tok_in,
  input  logic [IW-1:0]    idx_in,
  input  ptq_pkg::cmd_t    cmd,
  input  logic [IW-1:0]    cmd_idx,
  output ptq_pkg::tok_t    tok_out,
  output logic [IW-1:0]    idx_out
);
  import ptq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

  logic        valid;
  logic [63:0] ident;
  logic [63:0] due;
  logic [31:0] interval;
  logic [63:0] order;
  logic        take;

  // decide whether this cell beats the candidate carried in
  always_comb begin
    take = 1'b0;
    case (srch)
      SRCH_FREE: take = !valid && !tok_in.found;
      SRCH_ID:   take = valid && (key_id != 64'd0) && (ident == key_id) && !tok_in.found;
      SRCH_DUE:  take = valid && (due <= cur_time) &&
                        (!tok_in.found || (due < tok_in.due) ||
                         ((due == tok_in.due) && (order < tok_in.order)));
      default:   take = 1'b0;
    endcase
  end

  // pass the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.go <= 1'b0;
    end else begin
      tok_out.go <= tok_in.go;
    end
    if (take) begin
      tok_out.found    <= 1'b1;
      tok_out.periodic <= (interval != 32'd0);
      tok_out.ident    <= ident;
      tok_out.due      <= due;
      tok_out.order    <= order;
      idx_out          <= MY_IDX;
    end else begin
      tok_out.found    <= tok_in.found;
      tok_out.periodic <= tok_in.periodic;
      tok_out.ident    <= tok_in.ident;
      tok_out.due      <= tok_in.due;
      tok_out.order    <= tok_in.order;
      idx_out          <= idx_in;
    end
  end

  // apply writes addressed to this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd_idx == MY_IDX) begin
      case (cmd.kind)
        CMD_LOAD: begin
          valid    <= 1'b1;
          ident    <= cmd.ident;
          due      <= cmd.due;
          interval <= cmd.interval;
          order    <= cmd.order;
        end
        CMD_CLEAR: valid <= 1'b0;
        CMD_REARM: begin
          due   <= due + {32'd0, interval};
          order <= cmd.order;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/periodic_timer_queue.sv =====
// Schedule, cancel and query: the result is registered after one sweep of the chain;
// the next transaction is taken once the sequence has returned to idle.
// Tick: a sweep per fired entry, then a final sweep or, at MAX_FIRE fires, a flush; every
// search runs a token down the chain of ENTRY_COUNT cells, one cell a cycle.
// One transaction at a time; a result held by out_ready stalls the sequence and the input.
// Reset (synchronous): all entries empty, time 0, next id 1, order count 0.
module periodic_timer_queue #(
  parameter int ENTRY_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] delay,
  input  logic [31:0] period,
  input  logic [63:0] request_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  reply_kind,
  output logic [63:0] entry_id,
  output logic        ok,
  output logic        last
);
  import ptq_pkg::*;

  localparam int IW = $clog2(ENTRY_COUNT);

  state_t            state, state_next;
  kind_e_t           op_kind;
  logic [31:0]       op_delay;
  logic [31:0]       op_period;
  logic [63:0]       op_rid;
  logic [63:0]       cur_time;
  logic [63:0]       next_ident;
  logic [63:0]       next_order;
  logic [FIRE_W-1:0] fire_cnt;
  logic [FIRE_W-1:0] fire_cnt_inc;
  logic              have_pend;
  logic [63:0]       pend_id;
  logic              launch, launch_next;
  logic              res_found, res_periodic;
  logic [63:0]       res_ident;
  logic [IW-1:0]     res_idx;
  srch_e_t           srch;
  tok_t              tok [ENTRY_COUNT+1];
  logic [IW-1:0]     idx_c [ENTRY_COUNT+1];
  cmd_t              cmd;
  logic [IW-1:0]     cmd_idx;
  logic              emit, step, out_free;
  reply_e_t          e_kind;
  logic [63:0]       e_id;
  logic              e_ok, e_last;
  logic              accept;

  assign accept       = in_valid && in_ready;
  assign in_ready     = (state == ST_IDLE);
  assign out_free     = !out_valid || out_ready;
  assign fire_cnt_inc = fire_cnt + 1'b1;

  always_comb begin
    case (op_kind)
      KIND_TICK:  srch = SRCH_DUE;
      KIND_SCHED: srch = SRCH_FREE;
      default:    srch = SRCH_ID;
    endcase
  end

  // head of the chain
  always_comb begin
    tok[0]    = '0;
    tok[0].go = launch;
    idx_c[0]  = '0;
  end

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    ptq_cell #(.IW(IW), .CELL_INDEX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .srch    (srch),
      .cur_time(cur_time),
      .key_id  (op_rid),
      .tok_in  (tok[g]),
      .idx_in  (idx_c[g]),
      .cmd     (cmd),
      .cmd_idx (cmd_idx),
      .tok_out (tok[g+1]),
      .idx_out (idx_c[g+1])
    );
  end

  // outputs of the control sequence
  always_comb begin
    emit        = 1'b0;
    step        = 1'b0;
    launch_next = 1'b0;
    e_kind      = REPLY_FIRED;
    e_id        = pend_id;
    e_ok        = 1'b1;
    e_last      = 1'b1;
    cmd         = '0;
    cmd.kind    = CMD_NONE;
    cmd_idx     = res_idx;
    unique case (state)
      ST_IDLE: launch_next = accept;
      ST_SWEEP: ;
      ST_ACT: begin
        unique case (op_kind)
          KIND_TICK: begin
            if (res_found) begin
              emit   = have_pend;
              e_last = 1'b0;
              step   = !have_pend || out_free;
              if (step) begin
                cmd.kind    = res_periodic ? CMD_REARM : CMD_CLEAR;
                cmd.order   = next_order;
                launch_next = (fire_cnt_inc != FIRE_W'(MAX_FIRE));
              end
            end else begin
              emit = have_pend;
              step = !have_pend || out_free;
            end
          end
          KIND_SCHED: begin
            emit   = 1'b1;
            step   = out_free;
            e_kind = REPLY_SCHED;
            e_id   = res_found ? next_ident : 64'd0;
            e_ok   = res_found;
            if (step && res_found) begin
              cmd.kind     = CMD_LOAD;
              cmd.ident    = next_ident;
              cmd.due      = cur_time + {32'd0, op_delay};
              cmd.interval = op_period;
              cmd.order    = next_order;
            end
          end
          KIND_CANCEL: begin
            emit   = 1'b1;
            step   = out_free;
            e_kind = REPLY_CANCEL;
            e_id   = op_rid;
            e_ok   = res_found;
            if (step && res_found) begin
              cmd.kind = CMD_CLEAR;
            end
          end
          KIND_QUERY: begin
            emit   = 1'b1;
            step   = out_free;
            e_kind = REPLY_QUERY;
            e_id   = op_rid;
            e_ok   = res_found;
          end
        endcase
      end
      ST_FLUSH: begin
        emit = 1'b1;
        step = out_free;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_SWEEP;
      ST_SWEEP: if (tok[ENTRY_COUNT].go) state_next = ST_ACT;
      ST_ACT: begin
        if (step) begin
          if (op_kind == KIND_TICK && res_found) begin
            state_next = (fire_cnt_inc == FIRE_W'(MAX_FIRE)) ? ST_FLUSH : ST_SWEEP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: if (step) state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      cur_time   <= 64'd0;
      next_ident <= 64'd1;
      next_order <= 64'd0;
      fire_cnt   <= '0;
      have_pend  <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (accept) begin
        fire_cnt  <= '0;
        have_pend <= 1'b0;
        if (kind_e_t'(kind) == KIND_TICK) begin
          cur_time <= cur_time + 64'd1;
        end
      end
      if (state == ST_ACT && step && res_found) begin
        if (op_kind == KIND_SCHED) begin
          next_ident <= (next_ident == '1) ? 64'd1 : next_ident + 64'd1;
          next_order <= next_order + 64'd1;
        end else if (op_kind == KIND_TICK) begin
          have_pend <= 1'b1;
          fire_cnt  <= fire_cnt_inc;
          if (res_periodic) begin
            next_order <= next_order + 64'd1;
          end
        end
      end
    end
  end

  // hold the transaction and the search result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= kind_e_t'(kind);
      op_delay  <= delay;
      op_period <= period;
      op_rid    <= request_id;
    end
    if (state == ST_SWEEP && tok[ENTRY_COUNT].go) begin
      res_found    <= tok[ENTRY_COUNT].found;
      res_periodic <= tok[ENTRY_COUNT].periodic;
      res_ident    <= tok[ENTRY_COUNT].ident;
      res_idx      <= idx_c[ENTRY_COUNT];
    end
    if (state == ST_ACT && step && res_found) begin
      pend_id <= res_ident;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit && step) begin
      reply_kind <= e_kind;
      entry_id   <= e_id;
      ok         <= e_ok;
      last       <= e_last;
    end
  end

  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FIRE_W'(MAX_FIRE))
    else $error("fire count beyond limit");

  a_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SWEEP) && launch)
    else $error("accepted transaction did not start a sweep");

  a_token_state: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRY_COUNT].go |-> (state == ST_SWEEP))
    else $error("search token arrived outside a sweep");

  a_ident_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_ident != 64'd0)
    else $error("next id is zero");

endmodule
